### hdl/lph_pkg.sv
// Shared types and constants for the linear-probing hash table.
package lph_pkg;

    localparam int MAX_SLOTS    = 1024;
    localparam int FRAC_BITS    = 8;
    localparam int IDX_W        = 10;
    localparam int SIZE_W       = 11;
    localparam int KEY_W        = 31;
    localparam int CAND_W       = 12;
    localparam int DIVR_W       = 6;
    localparam int LOAD_W       = 20;

    // largest prime at or below MAX_SLOTS
    localparam logic [SIZE_W-1:0] LARGEST_PRIME = 11'd1021;

    localparam logic [SIZE_W-1:0] REQ_RESET = 11'd5;
    localparam logic [7:0]        THR_RESET = 8'd179;

    localparam logic REG_REQ_SIZE = 1'b0;
    localparam logic REG_LOAD_THR = 1'b1;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  slot_to_read;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   slot_index;
        logic signed [31:0] slot_key;
        logic [SIZE_W-1:0]  table_size;
        logic [SIZE_W-1:0]  entry_count;
        logic               grew;
        logic               error;
    } out_item_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_RD_RES, S_INIT, S_PS_CAND, S_PS_TEST, S_PS_DIV,
        S_LOAD, S_SCAN_RD, S_SCAN_WR, S_RE_START, S_RE_CHK, S_RE_LD, S_FINAL,
        S_PL_MOD, S_PL_DIV, S_PL_RD, S_PL_CHK, S_RES_INS, S_RES_ERR
    } ctrl_state_t;

    typedef struct packed {
        logic clr_wr;
        logic in_load;
        logic rd_issue;
        logic res_rd;
        logic init_cand;
        logic grow_cand;
        logic cand_inc;
        logic d_init;
        logic d_inc;
        logic div_ps;
        logic div_pl;
        logic size_found;
        logic size_fail;
        logic scan_start;
        logic scan_rd;
        logic scan_wr;
        logic re_start;
        logic re_rd;
        logic re_ld;
        logic final_ld;
        logic idx_load;
        logic pl_rd;
        logic probe_next;
        logic place_wr;
        logic res_ins;
        logic res_err;
    } dp_cmd_t;

    typedef struct packed {
        logic in_is_read;
        logic size_zero;
        logic cand_over;
        logic cand_small;
        logic d_sq_gt;
        logic div_done;
        logic rem_zero;
        logic load_gt;
        logic clr_last;
        logic scan_last;
        logic re_done;
        logic slot_valid;
        logic full;
        logic out_free;
    } dp_stat_t;

endpackage

### hdl/lph_div.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module lph_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lph_pkg::KEY_W-1:0]   dividend,
    input  logic [lph_pkg::SIZE_W-1:0]  divisor,
    output logic                        done,
    output logic [lph_pkg::SIZE_W-1:0]  rem
);

    logic [lph_pkg::KEY_W-1:0]  num_reg;
    logic [lph_pkg::SIZE_W-1:0] div_reg;
    logic [lph_pkg::SIZE_W-1:0] rem_reg;
    logic [4:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [lph_pkg::SIZE_W:0]   trial;
    logic [lph_pkg::SIZE_W:0]   diff;
    logic [lph_pkg::SIZE_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, num_reg[lph_pkg::KEY_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = diff[lph_pkg::SIZE_W-1:0];
        end
        else
        begin
            rem_next = trial[lph_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'(lph_pkg::KEY_W - 1);
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != '0);
            done_reg <= (cnt_reg == '0);
            cnt_reg  <= cnt_reg - 5'd1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[lph_pkg::KEY_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### hdl/lph_dp.sv
// Datapath: config registers, slot and scratch memories, counters, result register.
module lph_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [lph_pkg::SIZE_W-1:0]   cfg_data,
    input  lph_pkg::in_item_t            in_data,
    input  logic                         out_ready,
    input  lph_pkg::dp_cmd_t             cmd,
    output lph_pkg::dp_stat_t            stat,
    output logic                         out_valid,
    output lph_pkg::out_item_t           out_data
);

    logic [lph_pkg::SIZE_W-1:0] req_reg;
    logic [7:0]                 thr_reg;
    logic [lph_pkg::SIZE_W-1:0] size_reg;
    logic [lph_pkg::SIZE_W-1:0] count_reg;
    lph_pkg::in_item_t          in_reg;
    logic [lph_pkg::CAND_W-1:0] cand_reg;
    logic [lph_pkg::DIVR_W-1:0] d_reg;
    logic [lph_pkg::SIZE_W-1:0] old_reg;
    logic [lph_pkg::IDX_W-1:0]  scan_reg;
    logic [lph_pkg::SIZE_W-1:0] n_reg;
    logic [lph_pkg::SIZE_W-1:0] j_reg;
    logic [lph_pkg::KEY_W-1:0]  pkey_reg;
    logic [lph_pkg::IDX_W-1:0]  idx_reg;
    logic                       grew_reg;
    logic                       out_valid_reg;
    lph_pkg::out_item_t         out_reg;

    logic [lph_pkg::KEY_W:0]    slot_mem [lph_pkg::MAX_SLOTS];
    logic [lph_pkg::KEY_W:0]    slot_q;
    logic [lph_pkg::KEY_W-1:0]  scr_mem [lph_pkg::MAX_SLOTS];
    logic [lph_pkg::KEY_W-1:0]  scr_q;

    logic                       mem_we;
    logic [lph_pkg::IDX_W-1:0]  mem_waddr;
    logic [lph_pkg::KEY_W:0]    mem_wdata;
    logic                       mem_re;
    logic [lph_pkg::IDX_W-1:0]  mem_raddr;

    logic                       div_start;
    logic [lph_pkg::KEY_W-1:0]  div_num;
    logic [lph_pkg::SIZE_W-1:0] div_den;
    logic                       div_done;
    logic [lph_pkg::SIZE_W-1:0] div_rem;

    logic [lph_pkg::CAND_W-1:0] d_sq;
    logic [lph_pkg::LOAD_W-1:0] load_lhs;
    logic [lph_pkg::LOAD_W-1:0] load_rhs;
    logic [lph_pkg::IDX_W-1:0]  idx_inc;
    logic                       rd_hit;

    lph_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign div_start = cmd.div_ps | cmd.div_pl;
    assign div_num   = cmd.div_pl ? pkey_reg
                                  : {{(lph_pkg::KEY_W-lph_pkg::CAND_W){1'b0}}, cand_reg};
    assign div_den   = cmd.div_pl ? size_reg
                                  : {{(lph_pkg::SIZE_W-lph_pkg::DIVR_W){1'b0}}, d_reg};

    assign mem_we    = cmd.clr_wr | cmd.scan_wr | cmd.place_wr;
    assign mem_waddr = cmd.place_wr ? idx_reg : scan_reg;
    assign mem_wdata = cmd.place_wr ? {1'b1, pkey_reg} : '0;
    assign mem_re    = cmd.rd_issue | cmd.scan_rd | cmd.pl_rd;

    always_comb
    begin
        priority if (cmd.rd_issue)
        begin
            mem_raddr = in_reg.slot_to_read;
        end
        else if (cmd.scan_rd)
        begin
            mem_raddr = scan_reg;
        end
        else
        begin
            mem_raddr = idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            slot_q <= slot_mem[mem_raddr];
        end
        if (cmd.scan_wr && slot_q[lph_pkg::KEY_W])
        begin
            scr_mem[n_reg[lph_pkg::IDX_W-1:0]] <= slot_q[lph_pkg::KEY_W-1:0];
        end
        if (cmd.re_rd)
        begin
            scr_q <= scr_mem[j_reg[lph_pkg::IDX_W-1:0]];
        end
    end

    assign d_sq     = {{(lph_pkg::CAND_W-lph_pkg::DIVR_W){1'b0}}, d_reg}
                    * {{(lph_pkg::CAND_W-lph_pkg::DIVR_W){1'b0}}, d_reg};
    assign load_lhs = (lph_pkg::LOAD_W'(count_reg) + 20'd1) << lph_pkg::FRAC_BITS;
    assign load_rhs = {{(lph_pkg::LOAD_W-8){1'b0}}, thr_reg}
                    * {{(lph_pkg::LOAD_W-lph_pkg::SIZE_W){1'b0}}, size_reg};
    assign idx_inc  = idx_reg + 10'd1;
    assign rd_hit   = ({1'b0, in_reg.slot_to_read} < size_reg) && slot_q[lph_pkg::KEY_W];

    always_comb
    begin
        stat.in_is_read = in_data.action;
        stat.size_zero  = (size_reg == '0);
        stat.cand_over  = (cand_reg > lph_pkg::CAND_W'(lph_pkg::MAX_SLOTS));
        stat.cand_small = (cand_reg < 12'd2);
        stat.d_sq_gt    = (d_sq > cand_reg);
        stat.div_done   = div_done;
        stat.rem_zero   = (div_rem == '0);
        stat.load_gt    = (load_lhs > load_rhs);
        stat.clr_last   = (scan_reg == lph_pkg::IDX_W'(lph_pkg::MAX_SLOTS - 1));
        stat.scan_last  = (({1'b0, scan_reg} + 11'd1) == old_reg);
        stat.re_done    = (j_reg == n_reg);
        stat.slot_valid = slot_q[lph_pkg::KEY_W];
        stat.full       = (count_reg >= size_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg       <= lph_pkg::REQ_RESET;
            thr_reg       <= lph_pkg::THR_RESET;
            size_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            grew_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lph_pkg::REG_REQ_SIZE: req_reg <= cfg_data;
                    lph_pkg::REG_LOAD_THR: thr_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (cmd.size_found || cmd.re_start)
            begin
                size_reg  <= cand_reg[lph_pkg::SIZE_W-1:0];
                count_reg <= '0;
            end
            else if (cmd.size_fail)
            begin
                size_reg  <= lph_pkg::LARGEST_PRIME;
                count_reg <= '0;
            end
            else if (cmd.place_wr)
            begin
                count_reg <= count_reg + 11'd1;
            end
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
            end
            else if (cmd.clr_wr || cmd.scan_wr)
            begin
                scan_reg <= scan_reg + 10'd1;
            end
            if (cmd.in_load)
            begin
                grew_reg <= 1'b0;
            end
            else if (cmd.re_start)
            begin
                grew_reg <= 1'b1;
            end
            if (cmd.res_rd || cmd.res_ins || cmd.res_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            in_reg <= in_data;
        end
        if (cmd.init_cand)
        begin
            cand_reg <= {1'b0, req_reg};
        end
        else if (cmd.grow_cand)
        begin
            cand_reg <= {size_reg, 1'b0};
        end
        else if (cmd.cand_inc)
        begin
            cand_reg <= cand_reg + 12'd1;
        end
        if (cmd.d_init)
        begin
            d_reg <= 6'd2;
        end
        else if (cmd.d_inc)
        begin
            d_reg <= d_reg + 6'd1;
        end
        if (cmd.scan_start)
        begin
            old_reg <= size_reg;
            n_reg   <= '0;
        end
        else if (cmd.scan_wr && slot_q[lph_pkg::KEY_W])
        begin
            n_reg <= n_reg + 11'd1;
        end
        if (cmd.re_start)
        begin
            j_reg <= '0;
        end
        else if (cmd.re_ld)
        begin
            j_reg <= j_reg + 11'd1;
        end
        if (cmd.re_ld)
        begin
            pkey_reg <= scr_q;
        end
        else if (cmd.final_ld)
        begin
            pkey_reg <= in_reg.key;
        end
        if (cmd.idx_load)
        begin
            idx_reg <= div_rem[lph_pkg::IDX_W-1:0];
        end
        else if (cmd.probe_next)
        begin
            idx_reg <= ({1'b0, idx_inc} == size_reg) ? '0 : idx_inc;
        end
        if (cmd.res_rd)
        begin
            out_reg.slot_index  <= in_reg.slot_to_read;
            out_reg.slot_key    <= rd_hit ? {1'b0, slot_q[lph_pkg::KEY_W-1:0]} : '1;
            out_reg.table_size  <= size_reg;
            out_reg.entry_count <= count_reg;
            out_reg.grew        <= 1'b0;
            out_reg.error       <= 1'b0;
        end
        else if (cmd.res_ins)
        begin
            out_reg.slot_index  <= idx_reg;
            out_reg.slot_key    <= {1'b0, pkey_reg};
            out_reg.table_size  <= size_reg;
            out_reg.entry_count <= count_reg;
            out_reg.grew        <= grew_reg;
            out_reg.error       <= 1'b0;
        end
        else if (cmd.res_err)
        begin
            out_reg.slot_index  <= '0;
            out_reg.slot_key    <= '1;
            out_reg.table_size  <= size_reg;
            out_reg.entry_count <= count_reg;
            out_reg.grew        <= grew_reg;
            out_reg.error       <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### hdl/lph_ctrl.sv
// Controller state machine sequencing setup, growth, probing and results.
module lph_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lph_pkg::dp_stat_t stat,
    output lph_pkg::dp_cmd_t  cmd
);

    lph_pkg::ctrl_state_t state_reg, state_next;
    logic grow_mode_reg, grow_mode_next;
    logic final_reg, final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lph_pkg::S_CLEAR;
            grow_mode_reg <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grow_mode_reg <= grow_mode_next;
            final_reg     <= final_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        grow_mode_next = grow_mode_reg;
        final_next     = final_reg;
        unique case (state_reg)
            lph_pkg::S_CLEAR:
                if (stat.clr_last) state_next = lph_pkg::S_IDLE;
            lph_pkg::S_IDLE:
                if (in_valid)
                begin
                    priority if (stat.in_is_read) state_next = lph_pkg::S_RD;
                    else if (stat.size_zero)      state_next = lph_pkg::S_INIT;
                    else                          state_next = lph_pkg::S_LOAD;
                end
            lph_pkg::S_RD:
                state_next = lph_pkg::S_RD_RES;
            lph_pkg::S_RD_RES:
                if (stat.out_free) state_next = lph_pkg::S_IDLE;
            lph_pkg::S_INIT:
            begin
                grow_mode_next = 1'b0;
                state_next     = lph_pkg::S_PS_CAND;
            end
            lph_pkg::S_PS_CAND:
                priority if (stat.cand_over)
                    state_next = grow_mode_reg ? lph_pkg::S_FINAL : lph_pkg::S_LOAD;
                else if (!stat.cand_small)
                    state_next = lph_pkg::S_PS_TEST;
            lph_pkg::S_PS_TEST:
                if (stat.d_sq_gt)
                    state_next = grow_mode_reg ? lph_pkg::S_SCAN_RD : lph_pkg::S_LOAD;
                else
                    state_next = lph_pkg::S_PS_DIV;
            lph_pkg::S_PS_DIV:
                if (stat.div_done)
                    state_next = stat.rem_zero ? lph_pkg::S_PS_CAND : lph_pkg::S_PS_TEST;
            lph_pkg::S_LOAD:
                if (stat.load_gt)
                begin
                    grow_mode_next = 1'b1;
                    state_next     = lph_pkg::S_PS_CAND;
                end
                else
                begin
                    state_next = lph_pkg::S_FINAL;
                end
            lph_pkg::S_SCAN_RD:
                state_next = lph_pkg::S_SCAN_WR;
            lph_pkg::S_SCAN_WR:
                state_next = stat.scan_last ? lph_pkg::S_RE_START : lph_pkg::S_SCAN_RD;
            lph_pkg::S_RE_START:
            begin
                final_next = 1'b0;
                state_next = lph_pkg::S_RE_CHK;
            end
            lph_pkg::S_RE_CHK:
                state_next = stat.re_done ? lph_pkg::S_FINAL : lph_pkg::S_RE_LD;
            lph_pkg::S_RE_LD:
                state_next = lph_pkg::S_PL_MOD;
            lph_pkg::S_FINAL:
                if (stat.full)
                begin
                    state_next = lph_pkg::S_RES_ERR;
                end
                else
                begin
                    final_next = 1'b1;
                    state_next = lph_pkg::S_PL_MOD;
                end
            lph_pkg::S_PL_MOD:
                state_next = lph_pkg::S_PL_DIV;
            lph_pkg::S_PL_DIV:
                if (stat.div_done) state_next = lph_pkg::S_PL_RD;
            lph_pkg::S_PL_RD:
                state_next = lph_pkg::S_PL_CHK;
            lph_pkg::S_PL_CHK:
                priority if (stat.slot_valid) state_next = lph_pkg::S_PL_RD;
                else if (final_reg)           state_next = lph_pkg::S_RES_INS;
                else                          state_next = lph_pkg::S_RE_CHK;
            lph_pkg::S_RES_INS,
            lph_pkg::S_RES_ERR:
                if (stat.out_free) state_next = lph_pkg::S_IDLE;
            default:
                state_next = lph_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            lph_pkg::S_CLEAR:   cmd.clr_wr = 1'b1;
            lph_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.in_load = in_valid;
            end
            lph_pkg::S_RD:      cmd.rd_issue = 1'b1;
            lph_pkg::S_RD_RES:  cmd.res_rd = stat.out_free;
            lph_pkg::S_INIT:    cmd.init_cand = 1'b1;
            lph_pkg::S_PS_CAND:
                priority if (stat.cand_over) cmd.size_fail = !grow_mode_reg;
                else if (stat.cand_small)    cmd.cand_inc = 1'b1;
                else                         cmd.d_init = 1'b1;
            lph_pkg::S_PS_TEST:
                if (stat.d_sq_gt)
                begin
                    cmd.size_found = !grow_mode_reg;
                    cmd.scan_start = grow_mode_reg;
                end
                else
                begin
                    cmd.div_ps = 1'b1;
                end
            lph_pkg::S_PS_DIV:
                if (stat.div_done)
                begin
                    cmd.cand_inc = stat.rem_zero;
                    cmd.d_inc    = !stat.rem_zero;
                end
            lph_pkg::S_LOAD:    cmd.grow_cand = stat.load_gt;
            lph_pkg::S_SCAN_RD: cmd.scan_rd = 1'b1;
            lph_pkg::S_SCAN_WR: cmd.scan_wr = 1'b1;
            lph_pkg::S_RE_START: cmd.re_start = 1'b1;
            lph_pkg::S_RE_CHK:  cmd.re_rd = !stat.re_done;
            lph_pkg::S_RE_LD:   cmd.re_ld = 1'b1;
            lph_pkg::S_FINAL:   cmd.final_ld = !stat.full;
            lph_pkg::S_PL_MOD:  cmd.div_pl = 1'b1;
            lph_pkg::S_PL_DIV:  cmd.idx_load = stat.div_done;
            lph_pkg::S_PL_RD:   cmd.pl_rd = 1'b1;
            lph_pkg::S_PL_CHK:
            begin
                cmd.probe_next = stat.slot_valid;
                cmd.place_wr   = !stat.slot_valid;
            end
            lph_pkg::S_RES_INS: cmd.res_ins = stat.out_free;
            lph_pkg::S_RES_ERR: cmd.res_err = stat.out_free;
            default: ;
        endcase
    end

endmodule

### hdl/linear_probe_hash_insert_with_rehash.sv
// Top level of the open-addressing hash table with linear probing and rehash.
//
// Input channel in_valid/in_ready/in_data: action 0 inserts key, action 1
// reads slot slot_to_read. Every transfer produces exactly one result on
// out_valid/out_ready/out_data. Config writes (cfg_we, cfg_index, cfg_data)
// take effect at once: index 0 is the requested size, index 1 the load limit.
// One item is worked at a time; the next transfer is taken the cycle after
// the result is written. A read issues its slot read, then writes its result.
// An insert waits on the shared bit-serial remainder unit for key mod size,
// then reads and checks one probed slot after another. The first insert adds
// a prime search (one remainder per trial divisor). A growth adds the prime
// search, a scan that reads and clears each old slot and saves the stored
// keys, and one full placement per stored key.
// After reset the slot memory is swept empty, all MAX_SLOTS slots, with in_ready low.
// The result sits in an output register; a stalled receiver only holds the
// block once the next result is ready to be written.
module linear_probe_hash_insert_with_rehash (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [lph_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lph_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lph_pkg::out_item_t          out_data
);

    lph_pkg::dp_cmd_t  cmd;
    lph_pkg::dp_stat_t stat;

    lph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lph_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.entry_count <= out_data.table_size)
        else $error("entry count exceeds table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |-> !out_data.grew && out_data.slot_key == -1)
        else $error("refused insert reports growth or a key");

endmodule
